@@ rtl/tpm_pkg.sv @@
// Shared types and constants for the trapezoid PWM motor profile unit.
// Holds the phase and sequencer codes, register indexes and divider interface.
// No dependencies; used by tpm_div and trapezoid_pwm_motor_profile_unit.
package tpm_pkg;

	// Field widths
	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned DUTY_W   = 8;
	localparam int unsigned PHASE_W  = 3;
	localparam int unsigned TIME_W   = 16;
	localparam int unsigned ELAP_W   = TIME_W + 1;
	localparam int unsigned CFG_IDX_W = 3;

	// Stream widths, padded to whole bytes
	localparam int unsigned S_DATA_W = 16;
	localparam int unsigned M_DATA_W = 24;

	// Divider widths: dividend holds elapsed*peak or sample*255
	localparam int unsigned DIVD_W = TIME_W + DUTY_W;
	localparam int unsigned DIVS_W = TIME_W;
	localparam int unsigned DCNT_W = $clog2(DIVD_W);

	// Knob full scale
	localparam logic [DIVS_W-1:0] KNOB_FULL = DIVS_W'(1023);

	// Register reset values
	localparam logic [TIME_W-1:0] PRE_DELAY_RST  = TIME_W'(300);
	localparam logic [TIME_W-1:0] RAMP_UP_RST    = TIME_W'(1000);
	localparam logic [TIME_W-1:0] HOLD_RST       = TIME_W'(2500);
	localparam logic [TIME_W-1:0] RAMP_DOWN_RST  = TIME_W'(1000);
	localparam logic [TIME_W-1:0] POST_DELAY_RST = TIME_W'(1000);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PRE_DELAY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_UP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_DOWN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POST_DELAY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE    = 3'd5;

	// Profile phases
	typedef enum logic [PHASE_W-1:0] {
		PH_PRE  = 3'd0,
		PH_UP   = 3'd1,
		PH_HOLD = 3'd2,
		PH_DOWN = 3'd3,
		PH_POST = 3'd4
	} phase_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETTLE,
		ST_PEAK,
		ST_DUTY,
		ST_RDIV,
		ST_OUT
	} seq_state_t;

	// Divider request and response
	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ rtl/tpm_div.sv @@
// Shared restoring divider for the trapezoid PWM motor profile unit.
// One quotient bit per cycle; depends on tpm_pkg for widths and the req/rsp structs.
module tpm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tpm_pkg::div_req_t req,
	output tpm_pkg::div_rsp_t rsp
);

	logic                        busy_q;
	logic                        done_q;
	logic [tpm_pkg::DCNT_W-1:0]  count_q;
	logic [tpm_pkg::DIVS_W-1:0]  rem_q;
	logic [tpm_pkg::DIVD_W-1:0]  quo_q;
	logic [tpm_pkg::DIVS_W-1:0]  divisor_q;

	logic [tpm_pkg::DIVS_W:0]    trial;
	logic [tpm_pkg::DIVS_W:0]    diff;
	logic                        fits;

	// Trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, quo_q[tpm_pkg::DIVD_W-1]};
		diff  = trial - {1'b0, divisor_q};
		fits  = (trial >= {1'b0, divisor_q});
	end

	// Control: start, count the steps, flag the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				count_q <= '0;
			end else if (busy_q) begin
				if (count_q == tpm_pkg::DCNT_W'(tpm_pkg::DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Datapath: load operands, then shift in one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[tpm_pkg::DIVS_W-1:0] : trial[tpm_pkg::DIVS_W-1:0];
			quo_q <= {quo_q[tpm_pkg::DIVD_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ rtl/trapezoid_pwm_motor_profile_unit.sv @@
// Trapezoidal velocity profile generator: one PWM duty beat per millisecond tick beat.
// Top level: registers, sequencer, output register. Depends on tpm_pkg and tpm_div.
//
// Each input beat is one tick carrying a knob sample; each one gives exactly one output
// beat with left/right duty and the current phase. The unit takes one tick at a time:
// after a beat is accepted s_tready stays low until its result is in the output
// register. A tick passes through the accept, phase settling (one phase step a
// cycle, at most three steps), the duty state and the load state, plus a run of the
// shared 24-step divider for each division it needs: one for the peak when a ramp or
// the hold is entered and one for the ramp term in a ramp phase. The load also waits
// on a held-off master side. The next tick is accepted while a result still waits
// on the master side, as long as the output register can take it when ready.
module trapezoid_pwm_motor_profile_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tpm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tpm_pkg::TIME_W-1:0]      cfg_data,
	// Tick input
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [tpm_pkg::S_DATA_W-1:0]    s_tdata,   // [9:0] knob_sample
	// Duty output
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tpm_pkg::M_DATA_W-1:0]    m_tdata    // [7:0] left_pwm, [15:8] right_pwm,
	                                                   // [18:16] phase_now
);

	// Configuration registers
	logic [tpm_pkg::TIME_W-1:0] pre_delay_q;
	logic [tpm_pkg::TIME_W-1:0] ramp_up_q;
	logic [tpm_pkg::TIME_W-1:0] hold_q;
	logic [tpm_pkg::TIME_W-1:0] ramp_down_q;
	logic [tpm_pkg::TIME_W-1:0] post_delay_q;
	logic                       reverse_q;

	// Profile state
	tpm_pkg::seq_state_t          state_q, state_d;
	tpm_pkg::phase_t              phase_q, phase_next;
	logic [tpm_pkg::ELAP_W-1:0]   elapsed_q;
	logic [tpm_pkg::DUTY_W-1:0]   peak_q;
	logic [tpm_pkg::SAMPLE_W-1:0] sample_q;
	logic                         peak_pend_q;
	logic [tpm_pkg::DUTY_W-1:0]   duty_q;

	// Output register
	logic                         m_tvalid_q;
	logic [tpm_pkg::M_DATA_W-1:0] m_tdata_q;

	// Divider link
	tpm_pkg::div_req_t div_req;
	tpm_pkg::div_rsp_t div_rsp;

	// Combinational helpers
	logic [tpm_pkg::ELAP_W-1:0]  phase_len;
	logic                        settled;
	logic                        is_ramp;
	logic [tpm_pkg::TIME_W-1:0]  ramp_len;
	logic [tpm_pkg::DIVD_W-1:0]  knob_scaled;
	logic [tpm_pkg::DIVD_W-1:0]  ramp_prod;
	logic [tpm_pkg::DUTY_W-1:0]  ramp_term;
	logic [tpm_pkg::DUTY_W-1:0]  direct_duty;
	logic [tpm_pkg::DUTY_W-1:0]  ramp_duty;
	logic                        accept;
	logic                        out_free;

	tpm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;

	// Length of the current phase; ramps last one tick more than their register
	always_comb begin
		unique case (phase_q)
			tpm_pkg::PH_PRE:  phase_len = {1'b0, pre_delay_q};
			tpm_pkg::PH_UP:   phase_len = {1'b0, ramp_up_q} + 1'b1;
			tpm_pkg::PH_HOLD: phase_len = {1'b0, hold_q};
			tpm_pkg::PH_DOWN: phase_len = {1'b0, ramp_down_q} + 1'b1;
			default:          phase_len = {1'b0, post_delay_q};
		endcase
		settled = (elapsed_q < phase_len);
	end

	// Following phase in the cycle
	always_comb begin
		unique case (phase_q)
			tpm_pkg::PH_PRE:  phase_next = tpm_pkg::PH_UP;
			tpm_pkg::PH_UP:   phase_next = tpm_pkg::PH_HOLD;
			tpm_pkg::PH_HOLD: phase_next = tpm_pkg::PH_DOWN;
			tpm_pkg::PH_DOWN: phase_next = tpm_pkg::PH_POST;
			default:          phase_next = tpm_pkg::PH_PRE;
		endcase
	end

	// Duty arithmetic around the divider
	always_comb begin
		is_ramp     = (phase_q == tpm_pkg::PH_UP) || (phase_q == tpm_pkg::PH_DOWN);
		ramp_len    = (phase_q == tpm_pkg::PH_UP) ? ramp_up_q : ramp_down_q;
		// sample * 255 as (sample << 8) - sample
		knob_scaled = ({{(tpm_pkg::DIVD_W-tpm_pkg::SAMPLE_W){1'b0}}, sample_q}
		               << tpm_pkg::DUTY_W)
		            - {{(tpm_pkg::DIVD_W-tpm_pkg::SAMPLE_W){1'b0}}, sample_q};
		ramp_prod   = elapsed_q[tpm_pkg::TIME_W-1:0] * peak_q;
		// clamp the ramp term at the peak
		if (div_rsp.quotient > {{(tpm_pkg::DIVD_W-tpm_pkg::DUTY_W){1'b0}}, peak_q})
			ramp_term = peak_q;
		else
			ramp_term = div_rsp.quotient[tpm_pkg::DUTY_W-1:0];
		ramp_duty = (phase_q == tpm_pkg::PH_UP) ? ramp_term : peak_q - ramp_term;
		// duty that needs no division: delays, hold, zero-length ramps
		case (phase_q)
			tpm_pkg::PH_UP:   direct_duty = peak_q;
			tpm_pkg::PH_HOLD: direct_duty = peak_q;
			default:          direct_duty = '0;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tpm_pkg::ST_IDLE:   if (accept) state_d = tpm_pkg::ST_SETTLE;
			tpm_pkg::ST_SETTLE: if (settled)
				state_d = peak_pend_q ? tpm_pkg::ST_PEAK : tpm_pkg::ST_DUTY;
			tpm_pkg::ST_PEAK:   if (div_rsp.done) state_d = tpm_pkg::ST_DUTY;
			tpm_pkg::ST_DUTY:
				state_d = (is_ramp && ramp_len != '0) ? tpm_pkg::ST_RDIV : tpm_pkg::ST_OUT;
			tpm_pkg::ST_RDIV:   if (div_rsp.done) state_d = tpm_pkg::ST_OUT;
			tpm_pkg::ST_OUT:    if (out_free) state_d = tpm_pkg::ST_IDLE;
			default:            state_d = tpm_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and divider requests
	always_comb begin
		s_tready         = (state_q == tpm_pkg::ST_IDLE);
		div_req.start    = 1'b0;
		div_req.dividend = ramp_prod;
		div_req.divisor  = ramp_len;
		unique case (state_q)
			tpm_pkg::ST_SETTLE: begin
				if (settled && peak_pend_q) begin
					div_req.start    = 1'b1;
					div_req.dividend = knob_scaled;
					div_req.divisor  = tpm_pkg::KNOB_FULL;
				end
			end
			tpm_pkg::ST_DUTY: begin
				div_req.start = is_ramp && (ramp_len != '0);
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_delay_q  <= tpm_pkg::PRE_DELAY_RST;
			ramp_up_q    <= tpm_pkg::RAMP_UP_RST;
			hold_q       <= tpm_pkg::HOLD_RST;
			ramp_down_q  <= tpm_pkg::RAMP_DOWN_RST;
			post_delay_q <= tpm_pkg::POST_DELAY_RST;
			reverse_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tpm_pkg::REG_PRE_DELAY:  pre_delay_q  <= cfg_data;
				tpm_pkg::REG_RAMP_UP:    ramp_up_q    <= cfg_data;
				tpm_pkg::REG_HOLD:       hold_q       <= cfg_data;
				tpm_pkg::REG_RAMP_DOWN:  ramp_down_q  <= cfg_data;
				tpm_pkg::REG_POST_DELAY: post_delay_q <= cfg_data;
				tpm_pkg::REG_REVERSE:    reverse_q    <= cfg_data[0];
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	// Sequencer and profile state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tpm_pkg::ST_IDLE;
			phase_q     <= tpm_pkg::PH_PRE;
			elapsed_q   <= '0;
			peak_q      <= '0;
			peak_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				tpm_pkg::ST_IDLE: begin
					peak_pend_q <= 1'b0;
				end
				tpm_pkg::ST_SETTLE: begin
					// advance one phase per cycle until the elapsed count fits
					if (!settled) begin
						phase_q   <= phase_next;
						elapsed_q <= '0;
						if (phase_next == tpm_pkg::PH_UP || phase_next == tpm_pkg::PH_HOLD ||
						    phase_next == tpm_pkg::PH_DOWN)
							peak_pend_q <= 1'b1;
					end
				end
				tpm_pkg::ST_PEAK: begin
					if (div_rsp.done)
						peak_q <= div_rsp.quotient[tpm_pkg::DUTY_W-1:0];
				end
				tpm_pkg::ST_OUT: begin
					if (out_free)
						elapsed_q <= elapsed_q + 1'b1;
				end
				default: begin
					peak_pend_q <= peak_pend_q;
				end
			endcase
		end
	end

	// Capture the sample and the duty
	always_ff @(posedge clk) begin
		if (accept)
			sample_q <= s_tdata[tpm_pkg::SAMPLE_W-1:0];
		if (state_q == tpm_pkg::ST_DUTY)
			duty_q <= direct_duty;
		else if (state_q == tpm_pkg::ST_RDIV && div_rsp.done)
			duty_q <= ramp_duty;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == tpm_pkg::ST_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tpm_pkg::ST_OUT && out_free) begin
			m_tdata_q <= {{(tpm_pkg::M_DATA_W-2*tpm_pkg::DUTY_W-tpm_pkg::PHASE_W){1'b0}},
			              phase_q,
			              reverse_q ? duty_q : {tpm_pkg::DUTY_W{1'b0}},
			              reverse_q ? {tpm_pkg::DUTY_W{1'b0}} : duty_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// One tick at a time: no new beat right after an accept
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input beat accepted while a tick is in progress");

	// The divider is never restarted mid-run
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// Delay phases drive no duty
	a_delay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[18:16] == tpm_pkg::PH_PRE || m_tdata[18:16] == tpm_pkg::PH_POST)
		|-> m_tdata[15:0] == '0)
		else $error("non-zero duty in a delay phase");

	// At most one output drives at any time
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] == '0 || m_tdata[15:8] == '0))
		else $error("both bridge outputs driven");

	// A result appears only from the load state
	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == tpm_pkg::ST_OUT))
		else $error("output loaded outside the load state");

endmodule

@@ tb/testbench.sv @@
// Testbench for trapezoid_pwm_motor_profile_unit: drives knob tick beats, tracks the
// five-phase profile in its own model and checks every duty beat field by field.
// Depends on tpm_pkg and the unit under test; needs no files or arguments.
module testbench;

	// Spare register indexes: writes there must be ignored
	localparam logic [tpm_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [tpm_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	localparam int SETTLE_CYCLES = 70;
	localparam int MAX_GAP       = 20;
	localparam int RANDOM_TICKS  = 500;
	localparam int LIMIT_CYCLES  = 600000;

	typedef struct {
		logic [tpm_pkg::DUTY_W-1:0] left_duty;
		logic [tpm_pkg::DUTY_W-1:0] right_duty;
		tpm_pkg::phase_t            ph;
	} duty_beat_t;

	logic                          clk;
	logic                          arst_n    = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [tpm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tpm_pkg::TIME_W-1:0]    cfg_data  = '0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [tpm_pkg::S_DATA_W-1:0]  s_tdata   = '0;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [tpm_pkg::M_DATA_W-1:0]  m_tdata;

	// Shadow of the profile registers and sequencer state
	logic [tpm_pkg::TIME_W-1:0]    len_pre  = tpm_pkg::PRE_DELAY_RST;
	logic [tpm_pkg::TIME_W-1:0]    len_up   = tpm_pkg::RAMP_UP_RST;
	logic [tpm_pkg::TIME_W-1:0]    len_hold = tpm_pkg::HOLD_RST;
	logic [tpm_pkg::TIME_W-1:0]    len_down = tpm_pkg::RAMP_DOWN_RST;
	logic [tpm_pkg::TIME_W-1:0]    len_post = tpm_pkg::POST_DELAY_RST;
	logic                          rev_dir  = 1'b0;
	tpm_pkg::phase_t               cur_phase      = tpm_pkg::PH_PRE;
	logic [tpm_pkg::ELAP_W-1:0]    ticks_in_phase = '0;
	logic [tpm_pkg::DUTY_W-1:0]    peak_duty      = '0;

	duty_beat_t pending_duty_q[$];
	int         mismatches     = 0;
	int         src_idle_pct   = 0;
	int         sink_stall_pct = 0;
	int         hold_off_left  = 0;

	trapezoid_pwm_motor_profile_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Length of a phase in ticks; ramps last one tick longer than their register
	function automatic logic [tpm_pkg::ELAP_W-1:0] phase_span(input tpm_pkg::phase_t p);
		case (p)
			tpm_pkg::PH_PRE:  phase_span = {1'b0, len_pre};
			tpm_pkg::PH_UP:   phase_span = {1'b0, len_up} + 1'b1;
			tpm_pkg::PH_HOLD: phase_span = {1'b0, len_hold};
			tpm_pkg::PH_DOWN: phase_span = {1'b0, len_down} + 1'b1;
			default:          phase_span = {1'b0, len_post};
		endcase
	endfunction

	// Ramp share elapsed*peak/len, clipped at the peak; a zero length gives the peak
	function automatic int unsigned ramp_share(input logic [tpm_pkg::ELAP_W-1:0] e,
			input logic [tpm_pkg::TIME_W-1:0] len, input logic [tpm_pkg::DUTY_W-1:0] pk);
		int unsigned t;
		if (len == '0) begin
			return pk;
		end
		t = (32'(e) * 32'(pk)) / 32'(len);
		return (t < pk) ? t : pk;
	endfunction

	// Advance the profile by one tick and return the duty beat it produces
	function automatic duty_beat_t next_duty_beat(input logic [tpm_pkg::SAMPLE_W-1:0] knob);
		duty_beat_t  beat;
		int unsigned duty;
		bit          settled;
		settled = 1'b0;
		// Step through finished phases, skipping empty ones in the same tick
		for (int pass = 0; pass < 6; pass++) begin
			if (!settled) begin
				if (ticks_in_phase < phase_span(cur_phase)) begin
					settled = 1'b1;
				end else begin
					cur_phase      = (cur_phase == tpm_pkg::PH_POST) ? tpm_pkg::PH_PRE :
					                 tpm_pkg::phase_t'(cur_phase + 1);
					ticks_in_phase = '0;
					if (cur_phase inside {tpm_pkg::PH_UP, tpm_pkg::PH_HOLD,
					                      tpm_pkg::PH_DOWN}) begin
						peak_duty = tpm_pkg::DUTY_W'((32'(knob) * 255) / 1023);
					end
				end
			end
		end
		case (cur_phase)
			tpm_pkg::PH_UP:   duty = ramp_share(ticks_in_phase, len_up, peak_duty);
			tpm_pkg::PH_HOLD: duty = peak_duty;
			tpm_pkg::PH_DOWN: duty = peak_duty - ramp_share(ticks_in_phase, len_down, peak_duty);
			default:          duty = 0;
		endcase
		beat.left_duty  = rev_dir ? '0 : tpm_pkg::DUTY_W'(duty);
		beat.right_duty = rev_dir ? tpm_pkg::DUTY_W'(duty) : '0;
		beat.ph         = cur_phase;
		ticks_in_phase  = ticks_in_phase + 1'b1;
		return beat;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// Offer one tick beat after a random gap, hold it until accepted
	task automatic send_tick(input logic [tpm_pkg::S_DATA_W-1:0] word);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < src_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		pending_duty_q.push_back(next_duty_beat(word[tpm_pkg::SAMPLE_W-1:0]));
	endtask

	// Write one register once every duty beat is out and the unit has gone quiet
	task automatic write_reg(input logic [tpm_pkg::CFG_IDX_W-1:0] idx,
			input logic [tpm_pkg::TIME_W-1:0] val);
		s_tvalid <= 1'b0;
		while (pending_duty_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tpm_pkg::REG_PRE_DELAY:  len_pre  = val;
			tpm_pkg::REG_RAMP_UP:    len_up   = val;
			tpm_pkg::REG_HOLD:       len_hold = val;
			tpm_pkg::REG_RAMP_DOWN:  len_down = val;
			tpm_pkg::REG_POST_DELAY: len_post = val;
			tpm_pkg::REG_REVERSE:    rev_dir  = val[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_profile(input logic [tpm_pkg::TIME_W-1:0] pre,
			input logic [tpm_pkg::TIME_W-1:0] up, input logic [tpm_pkg::TIME_W-1:0] hold,
			input logic [tpm_pkg::TIME_W-1:0] down, input logic [tpm_pkg::TIME_W-1:0] post,
			input logic [tpm_pkg::TIME_W-1:0] rev);
		write_reg(tpm_pkg::REG_PRE_DELAY, pre);
		write_reg(tpm_pkg::REG_RAMP_UP, up);
		write_reg(tpm_pkg::REG_HOLD, hold);
		write_reg(tpm_pkg::REG_RAMP_DOWN, down);
		write_reg(tpm_pkg::REG_POST_DELAY, post);
		write_reg(tpm_pkg::REG_REVERSE, rev);
	endtask

	function automatic logic [tpm_pkg::S_DATA_W-1:0] random_knob_word();
		int r;
		logic [tpm_pkg::SAMPLE_W-1:0] knob;
		r = $urandom_range(0, 99);
		knob = (r < 10) ? '0 : (r < 20) ? 10'd1023 :
		       tpm_pkg::SAMPLE_W'($urandom_range(0, 1023));
		// Padding bits must be ignored
		if ($urandom_range(0, 9) == 0) begin
			return {6'($urandom), knob};
		end
		return {6'b0, knob};
	endfunction

	function automatic logic [tpm_pkg::TIME_W-1:0] random_len(input bit ramp);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			return tpm_pkg::TIME_W'($urandom_range(0, 65535));
		end else if (r < 12) begin
			return '1;
		end else if (r < 22) begin
			return '0;
		end
		return ramp ? tpm_pkg::TIME_W'($urandom_range(1, 12)) :
		              tpm_pkg::TIME_W'($urandom_range(0, 5));
	endfunction

	// Reset values: a few ticks of the default pre delay, padding bits set on one
	task automatic test_reset_defaults();
		send_tick(16'h0000);
		send_tick(16'h03FF);
		send_tick(16'hFC00 | 16'(10'd517));
		send_tick(16'h0001);
	endtask

	// Empty delays and hold, one-tick ramps; pre delay shortened below elapsed count
	task automatic test_zero_lengths();
		write_profile(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_tick(16'd1023);
		send_tick(16'd0);
		send_tick(16'd1022);
		send_tick(16'd1);
		send_tick(16'd1023);
		send_tick(16'd512);
		send_tick(16'd1023);
		send_tick(16'd4);
	endtask

	// Direction register: masking to one bit, and spare indexes ignored
	task automatic test_direction();
		write_reg(tpm_pkg::REG_RAMP_UP, 16'd2);
		write_reg(tpm_pkg::REG_HOLD, 16'd1);
		write_reg(tpm_pkg::REG_REVERSE, 16'hFFFF);
		write_reg(REG_SPARE_A, 16'h5A5A);
		send_tick(16'd1023);
		send_tick(16'd300);
		write_reg(tpm_pkg::REG_REVERSE, 16'hFFFE);
		write_reg(REG_SPARE_B, 16'hFFFF);
		send_tick(16'd1023);
		send_tick(16'd800);
	endtask

	// Longest phases, then shorten them while in progress
	task automatic test_long_phases();
		write_profile(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1);
		send_tick(16'd1023);
		send_tick(16'd1023);
		send_tick(16'd700);
		write_profile(16'd0, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0);
		send_tick(16'd1023);
		send_tick(16'd250);
		send_tick(16'd1023);
		send_tick(16'd999);
	endtask

	// Random profiles with bursts of random ticks, cycling through idling modes
	task automatic test_random_profiles();
		int sent;
		int batch;
		int burst;
		sent  = 0;
		batch = 0;
		while (sent < RANDOM_TICKS) begin
			case (batch % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
				default: begin src_idle_pct = 32; sink_stall_pct = 32; end
			endcase
			if ($urandom_range(0, 9) < 7) write_reg(tpm_pkg::REG_PRE_DELAY, random_len(1'b0));
			if ($urandom_range(0, 9) < 7) write_reg(tpm_pkg::REG_RAMP_UP, random_len(1'b1));
			if ($urandom_range(0, 9) < 7) write_reg(tpm_pkg::REG_HOLD, random_len(1'b0));
			if ($urandom_range(0, 9) < 7) write_reg(tpm_pkg::REG_RAMP_DOWN, random_len(1'b1));
			if ($urandom_range(0, 9) < 7) write_reg(tpm_pkg::REG_POST_DELAY, random_len(1'b0));
			if ($urandom_range(0, 9) < 5) begin
				write_reg(tpm_pkg::REG_REVERSE, tpm_pkg::TIME_W'($urandom));
			end
			if ($urandom_range(0, 9) == 0) begin
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
					tpm_pkg::TIME_W'($urandom));
			end
			burst = $urandom_range(12, 40);
			repeat (burst) send_tick(random_knob_word());
			sent += burst;
			batch++;
		end
	endtask

	// Hold the output off for a long stretch while ticks keep coming
	task automatic test_backpressure();
		write_profile(16'd1, 16'd5, 16'd2, 16'd5, 16'd1, 16'd0);
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_off_left  = 300;
		repeat (16) send_tick(random_knob_word());
	endtask

	// Output side: random stalls, or a counted hold-off when one is requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				hold_off_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	// Compare each accepted duty beat with the oldest prediction
	always @(posedge clk) begin : check_duty
		duty_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_duty_q.size() == 0) begin
				report_mismatch($sformatf("duty beat %h with none pending", m_tdata));
			end else begin
				want = pending_duty_q.pop_front();
				if (m_tdata[7:0] !== want.left_duty)
					report_mismatch($sformatf("left_pwm %h, want %h", m_tdata[7:0], want.left_duty));
				if (m_tdata[15:8] !== want.right_duty)
					report_mismatch($sformatf("right_pwm %h, want %h", m_tdata[15:8],
						want.right_duty));
				if (m_tdata[18:16] !== want.ph)
					report_mismatch($sformatf("phase_now %0d, want %0d", m_tdata[18:16], want.ph));
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_zero_lengths();
		test_direction();
		test_long_phases();
		test_random_profiles();
		test_backpressure();
		// Drain the outstanding beats, then let the unit go quiet
		s_tvalid <= 1'b0;
		while (pending_duty_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_duty_q.size() != 0) begin
			report_mismatch($sformatf("%0d duty beats never arrived", pending_duty_q.size()));
		end
		if (mismatches == 0) begin
			$display("trapezoid_pwm_motor_profile_unit verification clean");
		end else begin
			$display("trapezoid_pwm_motor_profile_unit verification failed");
		end
		$finish;
	end

	// Give up on a hung run
	initial begin
		#(LIMIT_CYCLES * 8);
		$display("MISMATCH: run timed out with %0d beats pending", pending_duty_q.size());
		$display("trapezoid_pwm_motor_profile_unit verification failed");
		$finish;
	end

endmodule
